// ===== src/pfde_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pfde_pkg: shared constants and font table for the page framebuffer engine.
// Holds action codes, glyph range constants and the 5x7 font ROM.
// ----------------------------------------------------------------------------
package pfde_pkg;

   localparam int DEF_WIDTH  = 128;
   localparam int DEF_HEIGHT = 64;

   localparam logic [2:0] ACT_CLEAR = 3'd0;
   localparam logic [2:0] ACT_PIXEL = 3'd1;
   localparam logic [2:0] ACT_GLYPH = 3'd2;
   localparam logic [2:0] ACT_BAR   = 3'd3;
   localparam logic [2:0] ACT_READ  = 3'd4;

   localparam logic [7:0] GLYPH_FIRST = 8'h20;
   localparam logic [7:0] GLYPH_LAST  = 8'h7E;
   localparam logic [7:0] GLYPH_SUBST = 8'h3F;
   localparam logic [7:0] FILL_FULL   = 8'd100;

   localparam logic [39:0] FONT_ROM [0:94] = '{
      40'h0000000000, 40'h00005F0000, 40'h0007000700, 40'h147F147F14,
      40'h242A7F2A12, 40'h2313086462, 40'h3649552250, 40'h0005030000,
      40'h001C224100, 40'h0041221C00, 40'h14083E0814, 40'h08083E0808,
      40'h0050300000, 40'h0808080808, 40'h0060600000, 40'h2010080402,
      40'h3E5149453E, 40'h00427F4000, 40'h4261514946, 40'h2141454B31,
      40'h1814127F10, 40'h2745454539, 40'h3C4A494930, 40'h0171090503,
      40'h3649494936, 40'h064949291E, 40'h0036360000, 40'h0056360000,
      40'h0814224100, 40'h1414141414, 40'h0041221408, 40'h0201510906,
      40'h324979413E, 40'h7E1111117E, 40'h7F49494936, 40'h3E41414122,
      40'h7F4141221C, 40'h7F49494941, 40'h7F09090901, 40'h3E4149497A,
      40'h7F0808087F, 40'h00417F4100, 40'h2040413F01, 40'h7F08142241,
      40'h7F40404040, 40'h7F020C027F, 40'h7F0408107F, 40'h3E4141413E,
      40'h7F09090906, 40'h3E4151215E, 40'h7F09192946, 40'h4649494931,
      40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F, 40'h3F4038403F,
      40'h6314081463, 40'h0708700807, 40'h6151494543, 40'h007F414100,
      40'h0204081020, 40'h0041417F00, 40'h0402010204, 40'h4040404040,
      40'h0001020400, 40'h2054545478, 40'h7F48444438, 40'h3844444420,
      40'h384444487F, 40'h3854545418, 40'h087E090102, 40'h0C5252523E,
      40'h7F08040478, 40'h00447D4000, 40'h2040443D00, 40'h7F10284400,
      40'h00417F4000, 40'h7C04180478, 40'h7C04040478, 40'h3844444438,
      40'h7C14141408, 40'h081414187C, 40'h7C08040408, 40'h4854545420,
      40'h043F444020, 40'h3C4040207C, 40'h1C2040201C, 40'h3C4030403C,
      40'h4428102844, 40'h0C5050503C, 40'h4464544C44, 40'h0008364100,
      40'h00007F0000, 40'h0041360800, 40'h1008081008
   };

   // Column c (0..4) of a glyph; column 0 sits in the top byte.
   function automatic logic [7:0] font_col(input logic [7:0] code, input logic [2:0] col);
      logic [7:0]  idx;
      logic [39:0] row;
      idx = code - GLYPH_FIRST;
      row = FONT_ROM[idx[6:0]];
      case (col)
         3'd0: font_col = row[39:32];
         3'd1: font_col = row[31:24];
         3'd2: font_col = row[23:16];
         3'd3: font_col = row[15:8];
         default: font_col = row[7:0];
      endcase
   endfunction

endpackage
`default_nettype wire

// ===== src/page_framebuffer_draw_engine.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// page_framebuffer_draw_engine
// 1-bit page-ordered frame buffer with a command-driven draw engine.
// ----------------------------------------------------------------------------
// Requests arrive on req_* (valid/stall) and each yields one response on
// rsp_* (valid/stall). One request is handled at a time; req_stall is high
// while a request is in flight or its response is held.
// The frame lives in one synchronous RAM with a registered read. Every
// drawing operation is a sequence of column read-modify-writes: each column
// byte is read, merged and written back. Set pixel: one byte per request.
// Glyph: 6 columns, up to 2 pages each. Bar: the fill width is computed
// first, then each column of the width is done over up to 2 pages. Clear
// and reset each sweep all FRAME_BYTES bytes (1024 by default), one per
// cycle. Read: the index is registered, the byte is read from the RAM and
// captured, and then the response is valid. After reset no request is
// taken until the clearing sweep ends.
// When rsp_stall is high the response is held and no new request is taken.
// ----------------------------------------------------------------------------
module page_framebuffer_draw_engine
   import pfde_pkg::*;
#(
   parameter int DISPLAY_WIDTH  = DEF_WIDTH,
   parameter int DISPLAY_HEIGHT = DEF_HEIGHT
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [2:0] req_action,
   input  wire logic [7:0] req_x_pos,
   input  wire logic [7:0] req_y_pos,
   input  wire logic       req_pixel_on,
   input  wire logic [7:0] req_char_code,
   input  wire logic [7:0] req_bar_width,
   input  wire logic [7:0] req_bar_fill,
   input  wire logic [9:0] req_read_index,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [7:0]      rsp_read_data,
   output logic            rsp_was_read
);
   localparam int PAGES       = (DISPLAY_HEIGHT + 7) / 8;
   localparam int FRAME_BYTES = PAGES * DISPLAY_WIDTH;
   localparam int AW          = $clog2(FRAME_BYTES);

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_DIV   = 3'd2;
   localparam logic [2:0] ST_RD    = 3'd3;
   localparam logic [2:0] ST_WR    = 3'd4;
   localparam logic [2:0] ST_RDATA = 3'd5;
   localparam logic [2:0] ST_RSP   = 3'd6;

   logic [7:0] mem [0:FRAME_BYTES-1];
   logic [7:0] mem_q;
   logic       we;
   logic [AW-1:0] waddr, raddr;
   logic [7:0] wdata;

   logic [2:0]  state_ff, state_in;
   logic [AW:0] clr_ff, clr_in;
   logic        boot_ff, boot_in;  // clearing sweep after reset, no response
   logic [2:0]  act_ff, act_in;
   logic [7:0]  x_ff, x_in, y_ff, y_in, code_ff, code_in, wid_ff, wid_in;
   logic        on_ff, on_in;
   logic [8:0]  col_ff, col_in;   // column offset within the shape
   logic        pg_ff, pg_in;     // 0: page of y, 1: next page
   logic [7:0]  data_ff, data_in;
   logic        rdv_ff, rdv_in;
   logic [AW-1:0] addr_ff, addr_in;
   logic        hit_ff, hit_in;
   logic [7:0]  span_ff, span_in;

   logic        div_start, div_done;
   logic [7:0]  div_span;

   pfde_fill_calc u_fill (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .bar_width (req_bar_width),
      .bar_fill  (req_bar_fill),
      .done      (div_done),
      .span      (div_span)
   );

   // Shape geometry for the current column/page.
   logic [7:0]  cx;
   logic [7:0]  py;
   logic [8:0]  ncols;
   logic [15:0] colmask;  // vertical pattern relative to y, rows 0..15
   logic [15:0] colval;
   logic [15:0] shifted_m, shifted_v;
   logic [7:0]  bm, bv;
   logic        rowok;
   logic [7:0]  glyph_code;
   logic [7:0]  gbits;
   logic [7:0]  inner;

   always_comb begin
      cx = x_ff + col_ff[7:0];
      py = {y_ff[7:3] + {4'd0, pg_ff}, 3'd0};
      glyph_code = (code_ff < GLYPH_FIRST || code_ff > GLYPH_LAST) ? GLYPH_SUBST : code_ff;
      gbits = font_col(glyph_code, col_ff[2:0]);
      colmask = '0;
      colval  = '0;
      ncols   = 9'd1;
      inner   = wid_ff - 8'd1;
      case (act_ff)
         ACT_PIXEL: begin
            ncols = 9'd1;
            colmask = 16'd1;
            colval  = {15'd0, on_ff};
         end
         ACT_GLYPH: begin
            ncols = 9'd6;
            colmask = 16'h00FF;
            colval  = (col_ff < 9'd5) ? {8'd0, gbits} : 16'd0;
         end
         ACT_BAR: begin
            // Zero width: left column x and right column x+255 only.
            if (wid_ff == 8'd0) begin
               ncols = 9'd256;
               if (col_ff == 9'd0 || col_ff == 9'd255) colmask = 16'h003E;
            end else begin
               ncols = {1'b0, wid_ff};
               colmask = 16'h0041;
               if (col_ff == 9'd0 || col_ff == {1'b0, inner}) colmask = 16'h007F;
               else if (col_ff[7:0] < span_ff && col_ff[7:0] < inner) colmask = 16'h007F;
            end
            colval = colmask;
         end
         default: begin
            ncols = 9'd1;
         end
      endcase
      // Align pattern rows (relative to y) to the byte page py.
      shifted_m = colmask << y_ff[2:0];
      shifted_v = colval << y_ff[2:0];
      bm = pg_ff ? shifted_m[15:8] : shifted_m[7:0];
      bv = pg_ff ? shifted_v[15:8] : shifted_v[7:0];
      // A page that wraps past 255 maps to rows y mod 256; py holds the wrap.
      rowok = ({1'b0, py} < 9'(DISPLAY_HEIGHT)) && ({1'b0, cx} < 9'(DISPLAY_WIDTH));
      // Rows of the page above the height limit are clipped.
      for (int r = 0; r < 8; r++) begin
         if (9'({1'b0, py}) + 9'(r) >= 9'(DISPLAY_HEIGHT)) bm[r] = 1'b0;
      end
   end

   always_comb begin
      state_in = state_ff;
      clr_in   = clr_ff;
      boot_in  = boot_ff;
      act_in = act_ff; x_in = x_ff; y_in = y_ff; code_in = code_ff; wid_in = wid_ff;
      on_in = on_ff; col_in = col_ff; pg_in = pg_ff; data_in = data_ff;
      rdv_in = rdv_ff; addr_in = addr_ff; hit_in = hit_ff; span_in = span_ff;
      we = 1'b0; waddr = addr_ff; wdata = '0; raddr = addr_ff;
      div_start = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            we = 1'b1;
            waddr = clr_ff[AW-1:0];
            clr_in = clr_ff + 1'b1;
            if (clr_ff == (AW+1)'(FRAME_BYTES - 1)) begin
               // A clear request answers once the sweep is done.
               state_in = boot_ff ? ST_IDLE : ST_RSP;
               boot_in  = 1'b0;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               act_in = req_action; x_in = req_x_pos; y_in = req_y_pos;
               code_in = req_char_code; wid_in = req_bar_width; on_in = req_pixel_on;
               col_in = '0; pg_in = 1'b0; data_in = '0; rdv_in = 1'b0;
               case (req_action)
                  ACT_CLEAR: begin
                     clr_in = '0;
                     state_in = ST_CLEAR;
                  end
                  ACT_PIXEL, ACT_GLYPH: state_in = ST_RD;
                  ACT_BAR: begin
                     div_start = 1'b1;
                     state_in = ST_DIV;
                  end
                  ACT_READ: begin
                     rdv_in = 1'b1;
                     hit_in = (32'(req_read_index) < FRAME_BYTES);
                     addr_in = AW'(req_read_index);
                     state_in = ST_RDATA;
                  end
                  default: state_in = ST_RSP;
               endcase
            end
         end
         ST_DIV: begin
            if (div_done) begin
               span_in = div_span;
               state_in = ST_RD;
            end
         end
         ST_RD: begin
            addr_in = AW'(32'(py[7:3]) * DISPLAY_WIDTH + 32'(cx));
            raddr = addr_in;
            hit_in = rowok && (bm != 8'd0);
            state_in = ST_WR;
         end
         ST_WR: begin
            we = hit_ff;
            wdata = (mem_q & ~bm) | (bv & bm);
            // Advance: page 0 then page 1 (only if y not page aligned).
            if (!pg_ff && y_ff[2:0] != 3'd0 && act_ff != ACT_PIXEL) begin
               pg_in = 1'b1;
               state_in = ST_RD;
            end else begin
               pg_in = 1'b0;
               col_in = col_ff + 9'd1;
               if (col_ff + 9'd1 >= ncols) state_in = ST_RSP;
               else state_in = ST_RD;
            end
         end
         ST_RDATA: begin
            state_in = ST_RSP;
            col_in = 9'd1;
         end
         ST_RSP: begin
            if (act_ff == ACT_READ && col_ff == 9'd1) begin
               data_in = hit_ff ? mem_q : 8'd0;
               col_in = '0;
            end else if (!rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      mem_q <= mem[raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
         boot_ff  <= 1'b1;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         boot_ff  <= boot_in;
      end
      act_ff <= act_in; x_ff <= x_in; y_ff <= y_in; code_ff <= code_in;
      wid_ff <= wid_in; on_ff <= on_in; col_ff <= col_in; pg_ff <= pg_in;
      data_ff <= data_in; rdv_ff <= rdv_in; addr_ff <= addr_in; hit_ff <= hit_in;
      span_ff <= span_in;
   end

   assign req_stall     = (state_ff != ST_IDLE);
   assign rsp_valid     = (state_ff == ST_RSP) && !(act_ff == ACT_READ && col_ff == 9'd1);
   assign rsp_read_data = data_ff;
   assign rsp_was_read  = rdv_ff;
endmodule
`default_nettype wire

// ===== src/pfde_fill_calc.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pfde_fill_calc: bar fill width
// Computes floor(width * fill / 100) by reciprocal multiplication: the product is registered, then scaled.
// ----------------------------------------------------------------------------
module pfde_fill_calc
   import pfde_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       start,
   input  wire logic [7:0] bar_width,
   input  wire logic [7:0] bar_fill,
   output logic            done,
   output logic [7:0]      span
);
   // 5243 / 2^19 is close enough to 1/100 for every product up to 255 * 100.
   localparam logic [12:0] FILL_RECIP = 13'd5243;

   logic [14:0] prod_ff, prod_in;
   logic [7:0]  quo_ff, quo_in;
   logic        busy_ff, busy_in;
   logic [7:0]  fill_c;
   logic [27:0] scaled;

   always_comb begin
      fill_c  = (bar_fill > FILL_FULL) ? FILL_FULL : bar_fill;
      prod_in = prod_ff;
      quo_in  = quo_ff;
      busy_in = busy_ff;
      scaled  = '0;
      if (start) begin
         prod_in = 15'(bar_width) * 15'(fill_c);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // The quotient is below 256, so bits 26:19 hold all of it.
         scaled  = 28'(prod_ff) * 28'(FILL_RECIP);
         quo_in  = scaled[26:19];
         busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      prod_ff <= prod_in;
      quo_ff  <= quo_in;
   end

   assign done = !busy_ff;
   assign span = quo_ff;
endmodule
`default_nettype wire

// ===== test/page_framebuffer_draw_engine_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// page_framebuffer_draw_engine_test
// Self-checking bench for the page framebuffer draw engine. A local frame
// model predicts every response; random drawing and read-back requests run
// with sender bursts, receiver stalls and a long receiver hold-off.
// ----------------------------------------------------------------------------
module page_framebuffer_draw_engine_test;
   import pfde_pkg::*;

   localparam int FW = DEF_WIDTH;
   localparam int FH = DEF_HEIGHT;
   localparam int FBYTES = ((FH + 7) / 8) * FW;
   localparam int IDLE_LIMIT = 20000;

   typedef struct packed {
      logic [7:0] data;
      logic       rd;
   } reply_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [2:0] req_action = ACT_READ;
   logic [7:0] req_x_pos = '0;
   logic [7:0] req_y_pos = '0;
   logic       req_pixel_on = 1'b0;
   logic [7:0] req_char_code = '0;
   logic [7:0] req_bar_width = '0;
   logic [7:0] req_bar_fill = '0;
   logic [9:0] req_read_index = '0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [7:0] rsp_read_data;
   logic       rsp_was_read;

   logic [7:0] frame_copy [0:FBYTES-1];
   reply_type  pending_replies[$];
   int         mismatches = 0;
   int         reads_checked = 0;
   int         requests_sent = 0;
   int         idle_cycles = 0;
   bit         hold_off = 1'b0;
   bit         stall_enable = 1'b0;

   page_framebuffer_draw_engine dut (.*);

   initial begin
      forever #6 clock = ~clock;
   end

   // Font column from an independent decode of the font table.
   function automatic logic [7:0] glyph_column(input logic [7:0] code, input int c);
      logic [39:0] word;
      logic [7:0]  g;
      g = (code < GLYPH_FIRST || code > GLYPH_LAST) ? GLYPH_SUBST : code;
      word = FONT_ROM[g - GLYPH_FIRST];
      return word[39 - 8 * c -: 8];
   endfunction

   task automatic put_pixel(input int x, input int y, input bit on);
      int cx, cy, idx;
      cx = x & 255;
      cy = y & 255;
      if (cx >= FW || cy >= FH) return;
      idx = (cy >> 3) * FW + cx;
      frame_copy[idx][cy & 7] = on;
   endtask

   task automatic apply_command(input logic [2:0] act, input logic [7:0] x,
                                input logic [7:0] y, input logic on,
                                input logic [7:0] code, input logic [7:0] w,
                                input logic [7:0] fill, input logic [9:0] ridx);
      reply_type r;
      int     span, f;
      logic [7:0] bits;
      r = '0;
      case (act)
         ACT_CLEAR: begin
            for (int i = 0; i < FBYTES; i++) frame_copy[i] = '0;
         end
         ACT_PIXEL: put_pixel(x, y, on);
         ACT_GLYPH: begin
            for (int c = 0; c < 5; c++) begin
               bits = glyph_column(code, c);
               for (int row = 0; row < 8; row++) put_pixel(x + c, y + row, bits[row]);
            end
            for (int row = 0; row < 8; row++) put_pixel(x + 5, y + row, 1'b0);
         end
         ACT_BAR: begin
            f = (fill > FILL_FULL) ? FILL_FULL : fill;
            span = w * f / FILL_FULL;
            for (int i = 0; i < w; i++) begin
               put_pixel(x + i, y, 1'b1);
               put_pixel(x + i, y + 6, 1'b1);
            end
            for (int j = 1; j < 6; j++) begin
               put_pixel(x, y + j, 1'b1);
               put_pixel(x + w + 255, y + j, 1'b1);
            end
            for (int i = 1; i < span && i + 1 < w; i++)
               for (int j = 1; j < 6; j++) put_pixel(x + i, y + j, 1'b1);
         end
         ACT_READ: begin
            r.rd = 1'b1;
            if (ridx < FBYTES) r.data = frame_copy[ridx];
         end
         default: ;
      endcase
      pending_replies.push_back(r);
   endtask

   task automatic send_request(input logic [2:0] act, input logic [7:0] x,
                               input logic [7:0] y, input logic on,
                               input logic [7:0] code, input logic [7:0] w,
                               input logic [7:0] fill, input logic [9:0] ridx);
      req_valid <= 1'b1;
      req_action <= act;
      req_x_pos <= x;
      req_y_pos <= y;
      req_pixel_on <= on;
      req_char_code <= code;
      req_bar_width <= w;
      req_bar_fill <= fill;
      req_read_index <= ridx;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      apply_command(act, x, y, on, code, w, fill, ridx);
      requests_sent++;
   endtask

   task automatic go_quiet();
      req_valid <= 1'b0;
   endtask

   task automatic wait_drained();
      go_quiet();
      @(posedge clock);
      while (pending_replies.size() != 0) @(posedge clock);
   endtask

   task automatic read_byte(input int idx);
      send_request(ACT_READ, 8'($urandom), 8'($urandom), 1'($urandom), 8'($urandom),
                   8'($urandom), 8'($urandom), 10'(idx));
   endtask

   // Random request, weighted toward small drawing and plenty of reads.
   task automatic send_random();
      int sel;
      logic [7:0] x, y, w, code, fill, junk;
      logic       on;
      logic [9:0] ridx;
      sel = $urandom_range(99);
      x = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(FW - 1));
      y = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(FH - 1));
      w = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(24));
      code = 8'($urandom);
      fill = 8'($urandom);
      junk = 8'($urandom);
      on = 1'($urandom);
      ridx = 10'($urandom);
      if (sel < 1)
         send_request(ACT_CLEAR, x, y, on, code, junk, fill, ridx);
      else if (sel < 25)
         send_request(ACT_PIXEL, x, y, on, code, junk, fill, ridx);
      else if (sel < 45)
         send_request(ACT_GLYPH, x, y, on, code, junk, fill, ridx);
      else if (sel < 55)
         send_request(ACT_BAR, x, y, on, code, w, fill, ridx);
      else if (sel < 97)
         send_request(ACT_READ, x, y, on, code, w, fill,
                      ($urandom_range(15) == 0) ? ridx : 10'($urandom_range(FBYTES - 1)));
      else
         send_request(3'($urandom_range(7, 5)), x, y, on, code, junk, fill, ridx);
   endtask

   task automatic test_directed();
      send_request(ACT_PIXEL, 8'd0, 8'd0, 1'b1, 8'h00, 8'h00, 8'h00, 10'h000);
      send_request(ACT_PIXEL, 8'd127, 8'd63, 1'b1, 8'hFF, 8'hFF, 8'hFF, 10'h3FF);
      send_request(ACT_PIXEL, 8'd255, 8'd255, 1'b1, 8'h00, 8'h00, 8'h00, 10'h000);
      read_byte(0);
      read_byte(FBYTES - 1);
      send_request(ACT_PIXEL, 8'd0, 8'd0, 1'b0, 8'h00, 8'h00, 8'h00, 10'h000);
      read_byte(0);
      send_request(ACT_GLYPH, 8'd10, 8'd3, 1'b0, 8'h30, 8'h00, 8'h00, 10'h000);
      send_request(ACT_GLYPH, 8'd124, 8'd60, 1'b0, 8'h7E, 8'h00, 8'h00, 10'h000);
      send_request(ACT_GLYPH, 8'd254, 8'd250, 1'b0, 8'h1F, 8'h00, 8'h00, 10'h000);
      send_request(ACT_GLYPH, 8'd40, 8'd16, 1'b0, 8'hFF, 8'h00, 8'h00, 10'h000);
      send_request(ACT_BAR, 8'd2, 8'd20, 1'b0, 8'h00, 8'd30, 8'd50, 10'h000);
      send_request(ACT_BAR, 8'd60, 8'd40, 1'b0, 8'h00, 8'd0, 8'd0, 10'h000);
      send_request(ACT_BAR, 8'd0, 8'd30, 1'b0, 8'h00, 8'd255, 8'd255, 10'h000);
      send_request(ACT_BAR, 8'd250, 8'd60, 1'b0, 8'h00, 8'd12, 8'd100, 10'h000);
      for (int i = 0; i < 4; i++) read_byte(FW * i + 2 + 12 * i);
      read_byte(10'h3FF);
      send_request(3'd5, 8'd1, 8'd1, 1'b1, 8'h41, 8'd9, 8'd9, 10'h001);
      send_request(3'd7, 8'd1, 8'd1, 1'b1, 8'h41, 8'd9, 8'd9, 10'h001);
      send_request(ACT_CLEAR, 8'd0, 8'd0, 1'b0, 8'h00, 8'h00, 8'h00, 10'h000);
      read_byte(FW + 2);
      wait_drained();
   endtask

   task automatic test_random_traffic(input int count);
      int sent;
      sent = 0;
      stall_enable = 1'b1;
      while (sent < count) begin
         for (int b = $urandom_range(1, 12); b > 0 && sent < count; b--) begin
            send_random();
            sent++;
         end
         if ($urandom_range(2) != 0) begin
            go_quiet();
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end
      end
      wait_drained();
   endtask

   // Receiver holds off while the sender keeps offering requests.
   task automatic test_backpressure();
      hold_off = 1'b1;
      for (int i = 0; i < 40; i++) send_random();
      wait_drained();
      for (int i = 0; i < 64; i++) read_byte($urandom_range(FBYTES - 1));
      wait_drained();
   endtask

   // Receiver: random stall pattern, plus a long counted hold-off when asked.
   always @(posedge clock) begin
      if (hold_off) begin
         rsp_stall <= 1'b1;
         repeat (300) @(posedge clock);
         rsp_stall <= 1'b0;
         hold_off = 1'b0;
      end else if (stall_enable) begin
         rsp_stall <= ($urandom_range(15) < 5) && ($urandom_range(63) > 8);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      reply_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_replies.size() == 0) begin
            $error("response with no request outstanding");
            mismatches++;
         end else begin
            want = pending_replies.pop_front();
            if (rsp_read_data !== want.data) begin
               $error("read_data expected %0h actual %0h", want.data, rsp_read_data);
               mismatches++;
            end
            if (rsp_was_read !== want.rd) begin
               $error("was_read expected %0b actual %0b", want.rd, rsp_was_read);
               mismatches++;
            end
            if (want.rd) reads_checked++;
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > IDLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   initial begin
      for (int i = 0; i < FBYTES; i++) frame_copy[i] = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_backpressure();
      test_random_traffic(1700);
      repeat (50) @(posedge clock);
      $display("Sent %0d requests (clear, pixel, glyph, bar, read, unused codes);",
               requests_sent);
      $display("%0d frame bytes read back and compared.", reads_checked);
      if (mismatches == 0 && pending_replies.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
